[rtl/sha1s_pkg.sv]
// shared types, constants and round helpers of the sha-1 stream hasher
`timescale 1ns / 1ps
package sha1s_pkg;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW = $clog2(QDEPTH);

  typedef enum logic [0:0] {
    CMD_ABSORB = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_e;

  // one classified beat handed from front to back
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data;
  } item_t;

  // one digest beat
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } dig_t;

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (r < 7'd20) f = (b & c) | (~b & d);
    else if (r < 7'd40) f = b ^ c ^ d;
    else if (r < 7'd60) f = (b & c) | (b & d) | (c & d);
    else f = b ^ c ^ d;
    return f;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] k;
    if (r < 7'd20) k = K0;
    else if (r < 7'd40) k = K1;
    else if (r < 7'd60) k = K2;
    else k = K3;
    return k;
  endfunction

endpackage

[rtl/sha1s_front.sv]
// front end: input beat queue between the port and the compression engine
`timescale 1ns / 1ps
module sha1s_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  sha1s_pkg::item_t item_i,
  output logic             avail_o,
  input  logic             take_i,
  output sha1s_pkg::item_t item_o
);
  import sha1s_pkg::*;

  item_t           mem_q [QDEPTH];
  logic [QAW-1:0]  wp_q, rp_q;
  logic [QAW:0]    cnt_q;
  logic            wr, rd;

  assign full_o  = (cnt_q == (QAW+1)'(QDEPTH));
  assign avail_o = (cnt_q != '0);
  assign wr      = push_i && !full_o;
  assign rd      = take_i && avail_o;
  assign item_o  = mem_q[rp_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= item_i;
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (QAW+1)'(wr) - (QAW+1)'(rd);
    end
  end
endmodule

[rtl/sha1s_back.sv]
// back end: block packing, padding, 80-round compression and digest output
`timescale 1ns / 1ps
module sha1s_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             avail_i,
  output logic             take_o,
  input  sha1s_pkg::item_t item_i,
  output logic             dvalid_o,
  input  logic             dtake_i,
  output sha1s_pkg::dig_t  dig_o
);
  import sha1s_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PAD  = 5'b00010,
    ST_RND  = 5'b00100,
    ST_ADD  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  state_e       state_q, state_d;
  logic [31:0]  w_q [16];
  logic [31:0]  h_q [5];
  logic [31:0]  v_q [5];
  logic [5:0]   fill_q;
  logic [63:0]  bits_q, len_q;
  logic [6:0]   rnd_q;
  logic         fin_q;
  logic         pad2_q;
  logic [2:0]   oidx_q;
  logic         put;
  logic [7:0]   put_byte;
  logic [3:0]   slot;
  logic [31:0]  wx, wcur, tsum;
  logic [7:0]   pad_byte;

  // byte to place while padding; the length goes only into the closing block
  always_comb begin
    if (fill_q >= 6'd56 && !pad2_q) pad_byte = len_q[8'(7'd63 - {fill_q[2:0], 3'b000}) -: 8];
    else pad_byte = 8'h00;
  end

  assign take_o   = (state_q == ST_IDLE) && avail_i;
  assign put      = take_o || (state_q == ST_PAD);
  assign put_byte = (state_q == ST_PAD) ? pad_byte :
                    (item_i.cmd == CMD_FINISH) ? PAD_BYTE : item_i.data;

  // round datapath
  assign slot = rnd_q[3:0];
  assign wx   = w_q[4'(slot + 4'd13)] ^ w_q[4'(slot + 4'd8)] ^ w_q[4'(slot + 4'd2)] ^ w_q[slot];
  assign wcur = (rnd_q < 7'd16) ? w_q[slot] : {wx[30:0], wx[31]};
  assign tsum = {v_q[0][26:0], v_q[0][31:27]} + round_f(rnd_q, v_q[1], v_q[2], v_q[3])
              + v_q[4] + round_k(rnd_q) + wcur;

  assign dvalid_o  = (state_q == ST_OUT);
  assign dig_o.word  = h_q[oidx_q];
  assign dig_o.index = oidx_q;
  assign dig_o.last  = (oidx_q == 3'd4);

  // next state; a second pad block follows when the length did not fit
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (take_o && (fill_q == 6'd63 || item_i.cmd == CMD_FINISH))
                 state_d = (fill_q == 6'd63) ? ST_RND : ST_PAD;
      ST_PAD:  if (fill_q == 6'd63) state_d = ST_RND;
      ST_RND:  if (rnd_q == 7'd79) state_d = ST_ADD;
      ST_ADD:  state_d = fin_q ? (pad2_q ? ST_PAD : ST_OUT) : ST_IDLE;
      ST_OUT:  if (dtake_i && oidx_q == 3'd4) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // schedule window, byte packing
  always_ff @(posedge clk_i) begin
    if (put) w_q[fill_q[5:2]][8'(7'd31 - {fill_q[1:0], 3'b000}) -: 8] <= put_byte;
    else if (state_q == ST_RND && rnd_q >= 7'd16) w_q[slot] <= wcur;
    if (take_o && item_i.cmd == CMD_FINISH) len_q <= bits_q;
    if (state_q == ST_RND) begin
      v_q[4] <= v_q[3];
      v_q[3] <= v_q[2];
      v_q[2] <= {v_q[1][1:0], v_q[1][31:2]};
      v_q[1] <= v_q[0];
      v_q[0] <= tsum;
    end else begin
      for (int i = 0; i < 5; i++) v_q[i] <= h_q[i];
    end
  end

  // control and chaining value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      bits_q  <= '0;
      rnd_q   <= '0;
      fin_q   <= 1'b0;
      pad2_q  <= 1'b0;
      oidx_q  <= '0;
      h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2; h_q[3] <= H3; h_q[4] <= H4;
    end else begin
      state_q <= state_d;
      if (put) fill_q <= fill_q + 1'b1;
      if (take_o) begin
        if (item_i.cmd == CMD_ABSORB) bits_q <= bits_q + 64'd8;
        else begin
          fin_q  <= 1'b1;
          pad2_q <= (fill_q > 6'd55);
        end
      end
      if (state_q == ST_RND) rnd_q <= rnd_q + 1'b1;
      if (state_q == ST_ADD) begin
        rnd_q <= '0;
        for (int i = 0; i < 5; i++) h_q[i] <= h_q[i] + v_q[i];
        pad2_q <= 1'b0;
      end
      if (state_q == ST_OUT && dtake_i) begin
        if (oidx_q == 3'd4) begin
          oidx_q <= '0;
          fin_q  <= 1'b0;
          bits_q <= '0;
          h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2; h_q[3] <= H3; h_q[4] <= H4;
        end else begin
          oidx_q <= oidx_q + 1'b1;
        end
      end
    end
  end
endmodule

[rtl/sha1_stream_hasher.sv]
// top level of the streaming sha-1 hasher
`timescale 1ns / 1ps
// Streaming SHA-1: push one beat per byte (command 0) or a finish beat
// (command 1); five digest beats, word 0 first, come out after each finish.
// An input queue of four beats lets bytes be pushed while a block is being
// compressed. The back end takes one byte a cycle while idle, and a full
// block then passes through the single-round compression unit and the
// chaining add before more bytes are taken; a finish adds the padding bytes
// at one a cycle and one or two compressions before the digest is presented.
module sha1_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        command_i,
  input  logic [7:0]  data_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import sha1s_pkg::*;

  item_t in_item, q_item;
  dig_t  dig;
  logic  avail, take, dvalid;

  assign in_item.cmd  = cmd_e'(command_i);
  assign in_item.data = data_byte_i;

  sha1s_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .item_i(in_item),
    .avail_o(avail), .take_i(take), .item_o(q_item)
  );

  sha1s_back u_back (
    .clk_i, .rst_ni, .avail_i(avail), .take_o(take), .item_i(q_item),
    .dvalid_o(dvalid), .dtake_i(pop), .dig_o(dig)
  );

  assign empty         = !dvalid;
  assign digest_word_o = dig.word;
  assign word_index_o  = dig.index;
  assign last_word_o   = dig.last;
endmodule
